// ===== sv/frame_difference_activity_detector_assert.svh =====
// ----------------------------------------------------------------------------
// frame difference activity detector assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef FRAME_DIFFERENCE_ACTIVITY_DETECTOR_ASSERT_SVH
`define FRAME_DIFFERENCE_ACTIVITY_DETECTOR_ASSERT_SVH

// same-cycle implication, off while reset is held
`define FDAD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fdad check failed");

// next-cycle implication, off while reset is held
`define FDAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fdad check failed");

// condition that must hold in the cycle after reset is sampled
`define FDAD_ASSERT_AFTER_RESET(label, clk, rst_n, cons) \
    label: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error("fdad check failed");

`endif

// ===== sv/fdad_pkg.sv =====
// ----------------------------------------------------------------------------
// fdad_pkg
// constants and types shared by the frame difference activity detector
// ----------------------------------------------------------------------------
`default_nettype none

package fdad_pkg;

    localparam int REGION_WIDTH  = 90;
    localparam int REGION_HEIGHT = 55;
    localparam int COUNT_MAX     = 5;
    localparam int PIXELS        = REGION_WIDTH * REGION_HEIGHT;

    // index counts up to PIXELS, memory address covers PIXELS entries
    localparam int IDX_W   = $clog2(PIXELS + 1);
    localparam int ADDR_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int COUNT_W = $clog2(COUNT_MAX + 1);

    localparam int CH_W    = 8;
    localparam int RGB_W   = 3 * CH_W;
    localparam int DIFF_W  = CH_W + 2;
    localparam int SUM_W   = 21;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // largest frame sum the region can produce
    localparam int SUM_LIMIT_INT = (PIXELS * 255 < 2097151) ? PIXELS * 255 : 2097151;
    localparam logic [SUM_W-1:0] SUM_LIMIT = SUM_W'(SUM_LIMIT_INT);

    // x / 3 == (x * 683) >> 11 for x below 766
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int PROD_W     = DIFF_W + 10;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic             mouth;
        logic             fin;
        logic             old_ok;
        logic [IDX_W-1:0] idx;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
    } t_cmd;

    typedef struct packed {
        logic             speaking;
        logic [SUM_W-1:0] frame_sum;
    } t_res;

endpackage

`default_nettype wire

// ===== sv/fdad_pix_if.sv =====
// ----------------------------------------------------------------------------
// fdad_pix_if
// pixel item channel: valid, ready and one region pixel
// ----------------------------------------------------------------------------
`default_nettype none

interface fdad_pix_if;
    import fdad_pkg::*;

    logic            valid;
    logic            ready;
    logic            mouth_found;
    logic [CH_W-1:0] pixel_red;
    logic [CH_W-1:0] pixel_green;
    logic [CH_W-1:0] pixel_blue;
    logic            last_pixel;

    modport source (
        output valid, mouth_found, pixel_red, pixel_green, pixel_blue, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, mouth_found, pixel_red, pixel_green, pixel_blue, last_pixel,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/fdad_res_if.sv =====
// ----------------------------------------------------------------------------
// fdad_res_if
// result item channel: valid, ready, speaking flag and frame sum
// ----------------------------------------------------------------------------
`default_nettype none

interface fdad_res_if;
    import fdad_pkg::*;

    logic             valid;
    logic             ready;
    logic             speaking;
    logic [SUM_W-1:0] frame_sum;

    modport source (
        output valid, speaking, frame_sum,
        input  ready
    );

    modport sink (
        input  valid, speaking, frame_sum,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/fdad_cfg_if.sv =====
// ----------------------------------------------------------------------------
// fdad_cfg_if
// configuration write channel for the activity threshold
// ----------------------------------------------------------------------------
`default_nettype none

interface fdad_cfg_if;
    import fdad_pkg::*;

    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] activity_threshold;

    modport source (
        output valid, activity_threshold,
        input  ready
    );

    modport sink (
        input  valid, activity_threshold,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/frame_difference_activity_detector.sv =====
// ----------------------------------------------------------------------------
// frame_difference_activity_detector
// mouth region frame difference with hysteresis speaking decision
// ----------------------------------------------------------------------------
// usage
//  - i_pix takes one item per cycle while i_pix.ready is high: a region pixel in raster order
//    (mouth_found 1, last_pixel on the final one) or a no-mouth item
//    (mouth_found 0) that closes the frame with sum 0
//  - o_res gives one item per closed frame: speaking and frame_sum
//  - i_cfg writes activity_threshold; write only while the block is idle
//  - throughput one item per cycle unless o_res stalls; the single store
//    port reads and writes the same entry per pixel, so it throttles nothing
//  - an accepted item passes the queue, the store read, the averaged
//    difference, then sum/counter into the result register
//  - a stalled o_res holds the result; pixels that close no frame keep
//    flowing, and a closing item waits in the back while the 4-entry queue
//    absorbs further items before i_pix.ready drops
//  - reset: counter at its maximum, sum and position at 0, threshold 0;
//    the store is not swept: a high-water mark makes unwritten entries read
//    as zero, so items are accepted from the first cycle after reset
// ----------------------------------------------------------------------------
`default_nettype none

module frame_difference_activity_detector (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fdad_pix_if.sink   i_pix,
    fdad_res_if.source o_res,
    fdad_cfg_if.sink   i_cfg
);
    import fdad_pkg::*;

    logic [SUM_W-1:0] r_thr;
    logic             fifo_full;
    logic             fifo_empty;
    logic             push;
    logic             pop;
    t_cmd             front_cmd;
    t_cmd             head_cmd;
    t_res             res;
    logic             res_valid;

    // threshold register, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg.valid) begin
            r_thr <= i_cfg.activity_threshold;
        end
    end

    // front: accept, number and classify items
    fdad_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_pix.valid),
        .o_ready       (i_pix.ready),
        .i_mouth_found (i_pix.mouth_found),
        .i_pixel_red   (i_pix.pixel_red),
        .i_pixel_green (i_pix.pixel_green),
        .i_pixel_blue  (i_pix.pixel_blue),
        .i_last_pixel  (i_pix.last_pixel),
        .i_full        (fifo_full),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    // queue decouples the front from stalls on the result side
    fdad_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (fifo_full),
        .i_pop   (pop),
        .o_empty (fifo_empty),
        .o_head  (head_cmd)
    );

    // back: store, difference, sum, counter and result register
    fdad_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!fifo_empty),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .i_threshold (r_thr),
        .o_res_valid (res_valid),
        .i_res_ready (o_res.ready),
        .o_res       (res)
    );

    assign o_res.valid     = res_valid;
    assign o_res.speaking  = res.speaking;
    assign o_res.frame_sum = res.frame_sum;

endmodule

`default_nettype wire

// ===== sv/fdad_front.sv =====
// ----------------------------------------------------------------------------
// fdad_front
// accepts items, assigns store positions and marks frame ends
// ----------------------------------------------------------------------------
`default_nettype none

module fdad_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_mouth_found,
    input  wire logic [7:0]            i_pixel_red,
    input  wire logic [7:0]            i_pixel_green,
    input  wire logic [7:0]            i_pixel_blue,
    input  wire logic                  i_last_pixel,
    input  wire logic                  i_full,
    output logic                       o_push,
    output fdad_pkg::t_cmd             o_cmd
);
    import fdad_pkg::*;

    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    // high-water mark: entries below it have been written since reset
    logic [IDX_W-1:0] r_hwm;
    logic [IDX_W-1:0] n_hwm;
    logic             at_end;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign at_end  = (r_idx >= IDX_W'(PIXELS - 1));

    always_comb begin
        o_cmd.mouth  = i_mouth_found;
        o_cmd.fin    = !i_mouth_found || i_last_pixel || at_end;
        o_cmd.old_ok = (r_idx < r_hwm);
        o_cmd.idx    = r_idx;
        o_cmd.red    = i_pixel_red;
        o_cmd.green  = i_pixel_green;
        o_cmd.blue   = i_pixel_blue;

        n_idx = r_idx;
        n_hwm = r_hwm;
        if (o_push) begin
            if (o_cmd.fin) begin
                n_idx = '0;
            end else begin
                n_idx = r_idx + IDX_W'(1);
            end
            if (i_mouth_found && (r_idx >= r_hwm)) begin
                n_hwm = r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_hwm <= '0;
        end else begin
            r_idx <= n_idx;
            r_hwm <= n_hwm;
        end
    end

endmodule

`default_nettype wire

// ===== sv/fdad_fifo.sv =====
// ----------------------------------------------------------------------------
// fdad_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module fdad_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  fdad_pkg::t_cmd      i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output fdad_pkg::t_cmd      o_head
);
    import fdad_pkg::*;

    t_cmd                  r_ent [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_PTR_W:0]   r_cnt;
    logic [FIFO_PTR_W:0]   n_cnt;

    assign o_full  = (r_cnt == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_ent[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (FIFO_PTR_W + 1)'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - (FIFO_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== sv/fdad_back.sv =====
// ----------------------------------------------------------------------------
// fdad_back
// store access, difference, frame sum, hysteresis counter and result register
// ----------------------------------------------------------------------------
`default_nettype none

module fdad_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cmd_valid,
    input  fdad_pkg::t_cmd                  i_cmd,
    output logic                            o_pop,
    input  wire logic [fdad_pkg::SUM_W-1:0] i_threshold,
    output logic                            o_res_valid,
    input  wire logic                       i_res_ready,
    output fdad_pkg::t_res                  o_res
);
    import fdad_pkg::*;

    // previous frame store, r g b packed high to low
    logic [RGB_W-1:0]   r_mem [PIXELS];
    logic [RGB_W-1:0]   r_rd;
    logic [ADDR_W-1:0]  addr;

    // stage 1: read data returning
    logic               r_s1_valid;
    t_cmd               r_s1;
    // stage 2: averaged difference of one pixel
    logic               r_s2_valid;
    logic               r_s2_mouth;
    logic               r_s2_fin;
    logic [CH_W-1:0]    r_s2_quo;

    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W-1:0]   n_sum;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               r_out_valid;
    t_res               r_out;

    logic               out_free;
    logic               s2_go;
    logic               s1_go;
    logic [RGB_W-1:0]   old_pix;
    logic [CH_W-1:0]    d_r;
    logic [CH_W-1:0]    d_g;
    logic [CH_W-1:0]    d_b;
    logic [DIFF_W-1:0]  d_sum;
    logic [PROD_W-1:0]  prod;
    logic [SUM_W:0]     sum_add;
    logic [SUM_W-1:0]   sum_sat;
    logic [SUM_W-1:0]   total;
    logic               gt;
    logic               lt;

    // handshake chain, output back to queue
    assign out_free = !r_out_valid || i_res_ready;
    assign s2_go    = r_s2_valid && (!r_s2_fin || out_free);
    assign s1_go    = r_s1_valid && (!r_s2_valid || s2_go);
    assign o_pop    = i_cmd_valid && (!r_s1_valid || s1_go);
    assign addr     = i_cmd.idx[ADDR_W-1:0];

    // read-first store: old pixel comes out, new pixel goes in
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd <= r_mem[addr];
            if (i_cmd.mouth) begin
                r_mem[addr] <= {i_cmd.red, i_cmd.green, i_cmd.blue};
            end
        end
    end

    always_comb begin
        old_pix = r_s1.old_ok ? r_rd : '0;
        d_r = (r_s1.red > old_pix[2*CH_W +: CH_W]) ? r_s1.red - old_pix[2*CH_W +: CH_W]
                                                   : old_pix[2*CH_W +: CH_W] - r_s1.red;
        d_g = (r_s1.green > old_pix[CH_W +: CH_W]) ? r_s1.green - old_pix[CH_W +: CH_W]
                                                   : old_pix[CH_W +: CH_W] - r_s1.green;
        d_b = (r_s1.blue > old_pix[0 +: CH_W]) ? r_s1.blue - old_pix[0 +: CH_W]
                                               : old_pix[0 +: CH_W] - r_s1.blue;
        d_sum = DIFF_W'(d_r) + DIFF_W'(d_g) + DIFF_W'(d_b);
        prod  = PROD_W'(d_sum) * PROD_W'(DIV3_MUL);
    end

    always_comb begin
        sum_add = {1'b0, r_sum} + (SUM_W + 1)'(r_s2_quo);
        sum_sat = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
        total   = r_s2_mouth ? sum_sat : '0;
        gt      = (total > i_threshold);
        lt      = (total < i_threshold);

        n_count = r_count;
        if (gt && (r_count != '0) && (r_count < COUNT_W'(COUNT_MAX))) begin
            n_count = r_count + COUNT_W'(1);
        end else if (lt && (r_count != '0)) begin
            n_count = r_count - COUNT_W'(1);
        end else if (gt && (r_count == '0)) begin
            n_count = COUNT_W'(COUNT_MAX);
        end

        n_sum = r_s2_fin ? '0 : sum_sat;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1 <= i_cmd;
        end
        if (s1_go) begin
            r_s2_mouth <= r_s1.mouth;
            r_s2_fin   <= r_s1.fin;
            r_s2_quo   <= prod[DIV3_SHIFT +: CH_W];
        end
        if (s2_go && r_s2_fin) begin
            r_out.speaking  <= (n_count != '0);
            r_out.frame_sum <= total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_sum       <= '0;
            r_count     <= COUNT_W'(COUNT_MAX);
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_s2_valid <= 1'b1;
            end else if (s2_go) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_go) begin
                r_sum <= n_sum;
                if (r_s2_fin) begin
                    r_count <= n_count;
                end
            end
            if (s2_go && r_s2_fin) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

`default_nettype wire

// ===== sv/fdad_checker.sv =====
// ----------------------------------------------------------------------------
// fdad_checker
// port-level checks on results, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_difference_activity_detector_assert.svh"

module fdad_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_valid,
    input  wire logic                       i_cfg_ready,
    input  wire logic [fdad_pkg::SUM_W-1:0] i_cfg_threshold,
    input  wire logic                       i_res_valid,
    input  wire logic                       i_res_ready,
    input  wire logic                       i_res_speaking,
    input  wire logic [fdad_pkg::SUM_W-1:0] i_res_frame_sum
);
    import fdad_pkg::*;

    // mirror of the threshold as written through the port
    logic [SUM_W-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_valid && i_cfg_ready) begin
            r_thr <= i_cfg_threshold;
        end
    end

    `FDAD_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_speaking) && $stable(i_res_frame_sum))
    `FDAD_ASSERT_IMPLY(a_sum_bound, i_clk, i_rst_n, i_res_valid, i_res_frame_sum <= SUM_LIMIT)
    `FDAD_ASSERT_IMPLY(a_above_speaks, i_clk, i_rst_n, i_res_valid && (i_res_frame_sum > r_thr), i_res_speaking)
    `FDAD_ASSERT_AFTER_RESET(a_reset_idle, i_clk, i_rst_n, !i_res_valid)

endmodule

bind frame_difference_activity_detector fdad_checker u_fdad_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cfg_valid     (i_cfg.valid),
    .i_cfg_ready     (i_cfg.ready),
    .i_cfg_threshold (i_cfg.activity_threshold),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_res_speaking  (o_res.speaking),
    .i_res_frame_sum (o_res.frame_sum)
);

`default_nettype wire
